>>> rtl/core/tdcp_pkg.sv
// shared types and constants of the hit pair frame packer
// no dependencies
package tdcp_pkg;

   localparam int MAX_HITS    = 256;
   localparam int NUM_FRAMES  = 256;
   localparam int FRAME_SHIFT = 13;

   localparam int HIT_AW   = $clog2(MAX_HITS);
   localparam int HIT_CW   = HIT_AW + 1;
   localparam int FRAME_W  = $clog2(NUM_FRAMES);
   localparam int RAW_W    = 31;
   localparam int PACK_W   = 32 + FRAME_W;
   localparam int REQ_DW   = 136;
   localparam int OP_W     = 3;

   localparam logic [OP_W-1:0] OP_START = 3'd0;
   localparam logic [OP_W-1:0] OP_HIT   = 3'd1;
   localparam logic [OP_W-1:0] OP_BOARD = 3'd2;
   localparam logic [OP_W-1:0] OP_PULL  = 3'd3;
   localparam logic [OP_W-1:0] OP_END   = 3'd4;

   localparam logic [1:0] EDGE_LEAD  = 2'd1;
   localparam logic [1:0] EDGE_TRAIL = 2'd2;
   localparam logic [3:0] LAST_TDC   = 4'd14;
   localparam logic [7:0] FRAME_FULL = 8'd255;

   typedef enum logic [2:0] {
      K_START, K_HIT, K_BOARD, K_PULL, K_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  word_a;   // header, raw hit, board number or trailer
      logic [31:0]  word_b;   // orbit word
   } cmd_type;

endpackage

>>> rtl/core/tdcp_front.sv
// front end: accepts items, classifies them into commands and queues them
// depends on tdcp_pkg
module tdcp_front import tdcp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,
   input  logic [OP_W-1:0]   req_tuser,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output cmd_type           cmd
);

   cmd_type     q_ff [2];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   cmd_type     cls;
   logic        known, push, pop;

   always_comb begin
      cls.kind   = K_PULL;
      cls.word_a = '0;
      cls.word_b = req_tdata[66:35];
      known      = 1'b1;
      case (req_tuser)
         OP_START: begin
            cls.kind   = K_START;
            cls.word_a = {1'b1, req_tdata[10:4], req_tdata[22:11], req_tdata[34:23]};
         end
         OP_HIT: begin
            cls.kind   = K_HIT;
            cls.word_a = {1'b0, req_tdata[67], req_tdata[71:68], req_tdata[74:72],
                          req_tdata[76:75], req_tdata[97:77]};
         end
         OP_BOARD: begin
            cls.kind   = K_BOARD;
            cls.word_a = {28'd0, req_tdata[3:0]};
         end
         OP_PULL: cls.kind = K_PULL;
         OP_END: begin
            cls.kind   = K_END;
            cls.word_a = {1'b1, req_tdata[128:98]};
         end
         default: known = 1'b0;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready && known;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/core/tdcp_back.sv
// back end: hit store, pairing, frame sort and word output register
// depends on tdcp_pkg
module tdcp_back import tdcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   typedef enum logic [19:0] {
      S_IDLE = 20'h00001, S_H1   = 20'h00002, S_H2   = 20'h00004, S_TRL  = 20'h00008,
      S_BINI = 20'h00010, S_BRDI = 20'h00020, S_BLDI = 20'h00040, S_BRDJ = 20'h00080,
      S_BCKJ = 20'h00100, S_BFRM = 20'h00200, S_BCNT = 20'h00400, S_SINI = 20'h00800,
      S_SRD  = 20'h01000, S_SCK  = 20'h02000, S_BDON = 20'h04000, S_PRD  = 20'h08000,
      S_PLD  = 20'h10000, S_PCNT = 20'h20000, S_PNX  = 20'h40000, S_PEMP = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [HIT_CW-1:0] raw_cnt_ff, raw_cnt_in, i_ff, i_in, j_ff, j_in, made_ff, made_in;
   logic [HIT_CW-1:0] k_ff, k_in, wp_ff, wp_in, pos_ff, pos_in, total_ff, total_in;
   logic              gch_ff, gch_in, hdr_ff, hdr_in;
   logic [3:0]        gtd_ff, gtd_in, board_ff, board_in;
   logic [RAW_W-1:0]  hi_ff, hi_in;
   logic [10:0]       wid_ff, wid_in;
   logic [FRAME_W-1:0] first_ff, first_in, last_ff, last_in, fcur_ff, fcur_in;
   logic [PACK_W-1:0] e_ff, e_in;
   logic [MAX_HITS-1:0]   used_ff;
   logic [NUM_FRAMES-1:0] fcv_ff;
   logic        out_v_ff, out_wv_ff, out_last_ff;
   logic [31:0] out_word_ff;

   // stores
   logic [RAW_W-1:0]   raw_mem [MAX_HITS];
   logic [PACK_W-1:0]  tmp_mem [MAX_HITS];
   logic [PACK_W-1:0]  pk_mem  [MAX_HITS];
   logic [7:0]         cnt_mem [NUM_FRAMES];
   logic [RAW_W-1:0]   raw_q_ff;
   logic [PACK_W-1:0]  tmp_q_ff, pk_q_ff;
   logic [7:0]         cnt_q_ff;

   logic [HIT_AW-1:0]  raw_ra, pk_ra;
   logic [FRAME_W-1:0] cnt_ra, hi_frame;
   logic               raw_we, tmp_we, pk_we, cnt_we, used_set, used_clr, fcv_set, fcv_clr;
   logic [7:0]         cnt_cur;
   logic [HIT_CW-1:0]  pos_nx;
   logic               out_free, emit, emit_wv, emit_last;
   logic [31:0]        emit_word;
   logic [20:0]        hi_t, q_t;
   logic [7:0]         board_plus;

   assign hi_t       = hi_ff[20:0];
   assign q_t        = raw_q_ff[20:0];
   assign hi_frame   = FRAME_W'(hi_t >> FRAME_SHIFT);
   assign cnt_cur    = fcv_ff[hi_frame] ? cnt_q_ff : 8'd0;
   assign pos_nx     = pos_ff + 1'b1;
   assign out_free   = !out_v_ff || rsp_tready;
   assign cmd_ready  = (state_ff == S_IDLE);
   assign board_plus = {4'd0, board_ff} + 8'd3;

   assign raw_ra = (state_ff == S_BRDJ) ? j_ff[HIT_AW-1:0] : i_ff[HIT_AW-1:0];
   assign pk_ra  = (state_ff == S_PRD) ? pos_ff[HIT_AW-1:0] : pos_nx[HIT_AW-1:0];
   assign cnt_ra = (state_ff == S_BFRM || state_ff == S_BCNT) ? hi_frame :
                   (state_ff == S_PLD) ? pk_q_ff[PACK_W-1:32] : e_ff[PACK_W-1:32];

   always_comb begin
      state_in = state_ff;  cmd_in = cmd_ff;    raw_cnt_in = raw_cnt_ff;
      i_in = i_ff;  j_in = j_ff;  made_in = made_ff;  k_in = k_ff;  wp_in = wp_ff;
      pos_in = pos_ff;  total_in = total_ff;  gch_in = gch_ff;  gtd_in = gtd_ff;
      hdr_in = hdr_ff;  board_in = board_ff;  hi_in = hi_ff;  wid_in = wid_ff;
      first_in = first_ff;  last_in = last_ff;  fcur_in = fcur_ff;  e_in = e_ff;
      raw_we = 1'b0;  tmp_we = 1'b0;  pk_we = 1'b0;  cnt_we = 1'b0;
      used_set = 1'b0;  used_clr = 1'b0;  fcv_set = 1'b0;  fcv_clr = 1'b0;
      emit = 1'b0;  emit_wv = 1'b1;  emit_last = 1'b0;  emit_word = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               case (cmd.kind)
                  K_START, K_END: begin
                     raw_cnt_in = '0;  pos_in = '0;  total_in = '0;  hdr_in = 1'b0;
                     first_in = '1;  last_in = '0;  fcv_clr = 1'b1;
                     state_in = (cmd.kind == K_START) ? S_H1 : S_TRL;
                  end
                  K_HIT: begin
                     if (raw_cnt_ff < HIT_CW'(MAX_HITS)) begin
                        raw_we     = 1'b1;
                        raw_cnt_in = raw_cnt_ff + 1'b1;
                     end
                  end
                  K_BOARD: state_in = S_BINI;
                  K_PULL:  state_in = S_PRD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_H1: if (out_free) begin
            emit = 1'b1;  emit_word = cmd_ff.word_a;  state_in = S_H2;
         end
         S_H2: if (out_free) begin
            emit = 1'b1;  emit_word = cmd_ff.word_b;  emit_last = 1'b1;  state_in = S_IDLE;
         end
         S_TRL: if (out_free) begin
            emit = 1'b1;  emit_word = cmd_ff.word_a;  state_in = S_IDLE;
         end
         S_BINI: begin
            used_clr = 1'b1;  fcv_clr = 1'b1;  made_in = '0;  first_in = '1;  last_in = '0;
            gch_in = 1'b0;  gtd_in = '0;  i_in = '0;
            state_in = (raw_cnt_ff == '0) ? S_SINI : S_BRDI;
         end
         S_BRDI: state_in = S_BLDI;
         S_BLDI: begin
            if (raw_q_ff[22:21] == EDGE_LEAD && raw_q_ff[30] == gch_ff &&
                raw_q_ff[29:26] == gtd_ff) begin
               hi_in = raw_q_ff;  wid_in = '0;  j_in = i_ff + 1'b1;
               state_in = (i_ff + 1'b1 == raw_cnt_ff) ? S_BFRM : S_BRDJ;
            end else if (i_ff + 1'b1 != raw_cnt_ff) begin
               i_in = i_ff + 1'b1;  state_in = S_BRDI;
            end else if (gch_ff && gtd_ff == LAST_TDC) begin
               state_in = S_SINI;
            end else begin
               i_in = '0;  state_in = S_BRDI;
               if (gtd_ff == LAST_TDC) begin
                  gtd_in = '0;  gch_in = 1'b1;
               end else begin
                  gtd_in = gtd_ff + 1'b1;
               end
            end
         end
         S_BRDJ: state_in = S_BCKJ;
         S_BCKJ: begin
            if (!used_ff[j_ff[HIT_AW-1:0]] && raw_q_ff[22:21] == EDGE_TRAIL &&
                raw_q_ff[30:23] == hi_ff[30:23]) begin
               wid_in = 11'(q_t - hi_t);  used_set = 1'b1;  state_in = S_BFRM;
            end else if (j_ff + 1'b1 == raw_cnt_ff) begin
               state_in = S_BFRM;
            end else begin
               j_in = j_ff + 1'b1;  state_in = S_BRDJ;
            end
         end
         S_BFRM: state_in = S_BCNT;
         S_BCNT: begin
            if (cnt_cur != FRAME_FULL) begin
               cnt_we = 1'b1;  fcv_set = 1'b1;  tmp_we = 1'b1;  made_in = made_ff + 1'b1;
               if (hi_frame < first_ff) first_in = hi_frame;
               if (hi_frame > last_ff) last_in = hi_frame;
            end
            // move on to the next leading candidate
            if (i_ff + 1'b1 != raw_cnt_ff) begin
               i_in = i_ff + 1'b1;  state_in = S_BRDI;
            end else if (gch_ff && gtd_ff == LAST_TDC) begin
               state_in = S_SINI;
            end else begin
               i_in = '0;  state_in = S_BRDI;
               if (gtd_ff == LAST_TDC) begin
                  gtd_in = '0;  gch_in = 1'b1;
               end else begin
                  gtd_in = gtd_ff + 1'b1;
               end
            end
         end
         S_SINI: begin
            fcur_in = first_ff;  k_in = '0;  wp_in = '0;
            state_in = (made_ff == '0) ? S_BDON : S_SRD;
         end
         S_SRD: state_in = S_SCK;
         S_SCK: begin
            if (tmp_q_ff[PACK_W-1:32] == fcur_ff) begin
               pk_we = 1'b1;  wp_in = wp_ff + 1'b1;
            end
            state_in = S_SRD;
            if (k_ff + 1'b1 == made_ff) begin
               k_in = '0;
               if (fcur_ff == last_ff) state_in = S_BDON;
               else fcur_in = fcur_ff + 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_BDON: begin
            raw_cnt_in = '0;  board_in = cmd_ff.word_a[3:0];  pos_in = '0;
            total_in = made_ff;  hdr_in = 1'b0;  state_in = S_IDLE;
         end
         S_PRD: state_in = (pos_ff >= total_ff) ? S_PEMP : S_PLD;
         S_PLD: begin
            e_in = pk_q_ff;  state_in = S_PCNT;
         end
         S_PCNT: begin
            if (!hdr_ff) begin
               if (out_free) begin
                  emit = 1'b1;  hdr_in = 1'b1;  state_in = S_IDLE;
                  emit_word = {board_plus, e_ff[PACK_W-1:32], 8'd0, cnt_q_ff};
               end
            end else if (pos_nx < total_ff) begin
               state_in = S_PNX;
            end else if (out_free) begin
               emit = 1'b1;  emit_word = e_ff[31:0];  emit_last = 1'b1;
               pos_in = pos_nx;  state_in = S_IDLE;
            end
         end
         S_PNX: if (out_free) begin
            emit = 1'b1;  emit_word = e_ff[31:0];  pos_in = pos_nx;  state_in = S_IDLE;
            if (pk_q_ff[PACK_W-1:32] != e_ff[PACK_W-1:32]) hdr_in = 1'b0;
         end
         S_PEMP: if (out_free) begin
            emit = 1'b1;  emit_wv = 1'b0;  state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (raw_we) raw_mem[raw_cnt_ff[HIT_AW-1:0]] <= cmd.word_a[RAW_W-1:0];
      if (tmp_we) tmp_mem[made_ff[HIT_AW-1:0]] <=
         {hi_frame, hi_ff[30], hi_ff[29:26], hi_ff[25:23], hi_t[12:0], wid_ff};
      if (pk_we)  pk_mem[wp_ff[HIT_AW-1:0]] <= tmp_q_ff;
      if (cnt_we) cnt_mem[hi_frame] <= cnt_cur + 8'd1;
      raw_q_ff <= raw_mem[raw_ra];
      tmp_q_ff <= tmp_mem[k_ff[HIT_AW-1:0]];
      pk_q_ff  <= pk_mem[pk_ra];
      cnt_q_ff <= cnt_mem[cnt_ra];
   end

   // a hit from the queue goes into the raw store at the accepting edge, if it has room
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  i_ff <= i_in;  j_ff <= j_in;  k_ff <= k_in;  wp_ff <= wp_in;
      hi_ff <= hi_in;  wid_ff <= wid_in;  fcur_ff <= fcur_in;  e_ff <= e_in;
      board_ff <= board_in;  gch_ff <= gch_in;  gtd_ff <= gtd_in;  made_ff <= made_in;
      if (emit) begin
         out_word_ff <= emit_word;
         out_wv_ff   <= emit_wv;
         out_last_ff <= emit_last;
      end
      if (reset) begin
         state_ff <= S_IDLE;  raw_cnt_ff <= '0;  pos_ff <= '0;  total_ff <= '0;
         hdr_ff <= 1'b0;  first_ff <= '1;  last_ff <= '0;  out_v_ff <= 1'b0;
         used_ff <= '0;  fcv_ff <= '0;
      end else begin
         state_ff <= state_in;  raw_cnt_ff <= raw_cnt_in;  pos_ff <= pos_in;
         total_ff <= total_in;  hdr_ff <= hdr_in;  first_ff <= first_in;  last_ff <= last_in;
         out_v_ff <= emit || (out_v_ff && !rsp_tready);
         if (used_clr) used_ff <= '0;
         else if (used_set) used_ff[j_ff[HIT_AW-1:0]] <= 1'b1;
         if (fcv_clr) fcv_ff <= '0;
         else if (fcv_set) fcv_ff[hi_frame] <= 1'b1;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = out_wv_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> rtl/core/tdc_hit_pair_frame_packer.sv
// top level of the hit pair frame packer
// depends on tdcp_pkg, tdcp_front and tdcp_back
//
// usage
//  - req channel: tuser carries the op (event start, hit, board end, pull, event end),
//    tdata carries all other input fields; unknown ops are taken and dropped
//  - rsp channel: tdata is the 32-bit word, tuser is word_valid, tlast marks the
//    orbit word and the last hit word of a board
//  - a two-entry command queue parts the front from the sequencer, and a one-word
//    output register parts the sequencer from the receiver
// sequencing
//  - hit: one item per cycle while the sequencer is idle, one raw store write each
//    while the store has room
//  - event start: H1 emits the header word, then H2 the orbit word
//  - pull: PRD, then PEMP (no word left) or PLD and PCNT, which may hand on to PNX
//  - board end: pairing scans the n raw hits (one raw store read at a time) once for
//    each of 30 converter groups; the frame sort then scans the paired list per frame
// reset clears the state, the hit and word counts and flags; stores need no clearing
// a stalled receiver holds the output word, the sequencer then waits, the queue
// fills and req_tready falls
module tdc_hit_pair_frame_packer import tdcp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // board_index, module_id, event_count, bunch_id, orbit_id, chain_sel,
   // tdc_index, channel_no, edge_bits, hit_time, fault_word, zero fill
   input  logic [REQ_DW-1:0] req_tdata,
   // op
   input  logic [OP_W-1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_word
   output logic [31:0]       rsp_tdata,
   // word_valid
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   cmd_type cmd;
   logic    cmd_valid, cmd_ready;

   tdcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   tdcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/sv/tb_tdc_hit_pair_frame_packer.sv
// self-checking testbench of the hit pair frame packer: event words, pairing, frame sort, pulls
// depends on tdcp_pkg and the tdc_hit_pair_frame_packer rtl
`timescale 1ns / 100ps

module tb_tdc_hit_pair_frame_packer;
   import tdcp_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int HOLD_CYCLES    = 400;

   // scoreboard: keeps its own copy of the packer state and the words it must emit
   class pair_pack_scoreboard;
      typedef struct packed {
         logic [31:0] word;
         logic        valid;
         logic        last;
      } out_word_type;

      out_word_type  pend_words[$];
      int            errors;
      int            n_checked;
      bit [30:0]     raw_hits[MAX_HITS];
      int            raw_n;
      int            frame_cnt[NUM_FRAMES];
      bit [39:0]     sorted_words[MAX_HITS];
      int            cur_pos;
      int            cur_total;
      bit [3:0]      cur_board;
      bit            hdr_done;

      function new();
         errors    = 0;
         n_checked = 0;
         cur_board = 0;
         clear_event();
      endfunction

      function void clear_event();
         raw_n = 0;
         foreach (frame_cnt[f]) frame_cnt[f] = 0;
         cur_pos   = 0;
         cur_total = 0;
         hdr_done  = 0;
      endfunction

      function void push_word(logic [31:0] w, logic v, logic l);
         out_word_type o;
         o.word  = w;
         o.valid = v;
         o.last  = l;
         pend_words.push_back(o);
      endfunction

      // pair leading with trailing hits per converter, then bucket by frame
      function void pair_board(bit [3:0] board);
         bit        used[MAX_HITS];
         bit [39:0] tmp[MAX_HITS];
         int        start[NUM_FRAMES];
         int        made;
         int        acc;
         bit [30:0] h;
         bit [30:0] q;
         bit [20:0] diff;
         bit [10:0] wid;
         bit [7:0]  f;
         made = 0;
         foreach (used[i]) used[i] = 0;
         foreach (frame_cnt[i]) frame_cnt[i] = 0;
         for (int g = 0; g < 30; g++) begin
            for (int i = 0; i < raw_n; i++) begin
               h = raw_hits[i];
               if (h[30] != (g / 15) || h[29:26] != (g % 15) || h[22:21] != EDGE_LEAD)
                  continue;
               wid = 0;
               for (int j = i + 1; j < raw_n; j++) begin
                  q = raw_hits[j];
                  if (used[j] || q[22:21] != EDGE_TRAIL || q[25:23] != h[25:23] ||
                      q[29:26] != h[29:26] || q[30] != h[30])
                     continue;
                  diff = q[20:0] - h[20:0];
                  wid = diff[10:0];
                  used[j] = 1;
                  break;
               end
               f = h[20:13];
               if (frame_cnt[f] >= 255)
                  continue;   // frame full, hit dropped
               frame_cnt[f]++;
               tmp[made] = {f, h[30], h[29:26], h[25:23], h[12:0], wid};
               made++;
            end
         end
         acc = 0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            start[i] = acc;
            acc += frame_cnt[i];
         end
         for (int i = 0; i < made; i++) begin
            f = tmp[i][39:32];
            sorted_words[start[f]] = tmp[i];
            start[f]++;
         end
         raw_n     = 0;
         cur_board = board;
         cur_pos   = 0;
         cur_total = made;
         hdr_done  = 0;
      endfunction

      function void pull_word();
         bit [39:0] e;
         bit [7:0]  f;
         bit [7:0]  bcode;
         if (cur_pos >= cur_total) begin
            push_word(32'd0, 1'b0, 1'b0);
            return;
         end
         e = sorted_words[cur_pos];
         f = e[39:32];
         if (!hdr_done) begin
            hdr_done = 1;
            bcode = {4'd0, cur_board} + 8'd3;
            push_word({bcode, f, 8'd0, 8'(frame_cnt[f])}, 1'b1, 1'b0);
            return;
         end
         cur_pos++;
         if (cur_pos < cur_total && sorted_words[cur_pos][39:32] != f)
            hdr_done = 0;
         push_word(e[31:0], 1'b1, cur_pos == cur_total);
      endfunction

      // note one accepted input item
      function void note_item(logic [2:0] op, logic [135:0] d);
         case (op)
            OP_START: begin
               clear_event();
               push_word({1'b1, d[10:4], d[22:11], d[34:23]}, 1'b1, 1'b0);
               push_word(d[66:35], 1'b1, 1'b1);
            end
            OP_HIT: begin
               if (raw_n < MAX_HITS) begin
                  raw_hits[raw_n] = {d[67], d[71:68], d[74:72], d[76:75], d[97:77]};
                  raw_n++;
               end
            end
            OP_BOARD: pair_board(d[3:0]);
            OP_PULL:  pull_word();
            OP_END: begin
               clear_event();
               push_word({1'b1, d[128:98]}, 1'b1, 1'b0);
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      // check one accepted result against the oldest pending word
      task check_word(logic [31:0] w, logic v, logic l);
         out_word_type o;
         n_checked++;
         if (pend_words.size() == 0) begin
            report($sformatf("unexpected word %h", w));
            return;
         end
         o = pend_words.pop_front();
         if (w !== o.word)
            report($sformatf("word %h, want %h", w, o.word));
         if (v !== o.valid)
            report($sformatf("word_valid %b, want %b (word %h)", v, o.valid, o.word));
         if (l !== o.last)
            report($sformatf("run_last %b, want %b (word %h)", l, o.last, o.word));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic [OP_W-1:0]   req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;

   pair_pack_scoreboard sb = new();

   int  snd_idle = 0;        // percent of cycles the sender idles
   int  rcv_idle = 0;        // percent of cycles the receiver stalls
   bit  hold_req = 0;        // asks the receiver for one long hold-off
   int  items_sent = 0;
   int  quiet_cycles = 0;
   int  max_pull_run = 0;

   tdc_hit_pair_frame_packer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_cnt;
      hold_cnt = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // watchdog: cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d words still pending", sb.pend_words.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // random fill so every tdata bit below the zero fill moves, then the used fields are overlaid
   function automatic logic [135:0] rnd_data();
      logic [135:0] r;
      r = 136'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r[135:129] = '0;
      return r;
   endfunction

   function automatic logic [135:0] start_data(logic [6:0] mid, logic [11:0] evc,
                                               logic [11:0] bx, logic [31:0] orbit);
      logic [135:0] d;
      d = rnd_data();
      d[10:4]  = mid;
      d[22:11] = evc;
      d[34:23] = bx;
      d[66:35] = orbit;
      return d;
   endfunction

   function automatic logic [135:0] hit_data(logic chain, logic [3:0] tdc, logic [2:0] ch,
                                             logic [1:0] edge_v, logic [20:0] t);
      logic [135:0] d;
      d = rnd_data();
      d[67]    = chain;
      d[71:68] = tdc;
      d[74:72] = ch;
      d[76:75] = edge_v;
      d[97:77] = t;
      return d;
   endfunction

   function automatic logic [135:0] board_data(logic [3:0] b);
      logic [135:0] d;
      d = rnd_data();
      d[3:0] = b;
      return d;
   endfunction

   function automatic logic [135:0] end_data(logic [30:0] fault);
      logic [135:0] d;
      d = rnd_data();
      d[128:98] = fault;
      return d;
   endfunction

   // offer one item, with random idle cycles ahead of it, and wait for the handshake
   task send_item(logic [2:0] op, logic [135:0] d);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(op, d);
      items_sent++;
   endtask

   task send_hit(logic chain, logic [3:0] tdc, logic [2:0] ch, logic [1:0] e,
                 logic [20:0] t);
      send_item(OP_HIT, hit_data(chain, tdc, ch, e, t));
   endtask

   task send_start();
      send_item(OP_START, start_data(7'($urandom), 12'($urandom), 12'($urandom), $urandom));
   endtask

   // pull words until the board is drained, sometimes leaving some or pulling past the end
   task drain_board();
      int run;
      run = 0;
      while (sb.cur_pos < sb.cur_total && $urandom_range(29) != 0) begin
         send_item(OP_PULL, rnd_data());
         run++;
      end
      if ($urandom_range(3) == 0)
         send_item(OP_PULL, rnd_data());
      if (run > max_pull_run)
         max_pull_run = run;
   endtask

   // one board of random hits: mostly lead/trail pairs inside a few frames
   task rand_board();
      int         n;
      bit         wide;
      logic [7:0] fbase;
      logic [20:0] t;
      logic [3:0] tdc;
      logic [2:0] ch;
      logic       chain;
      n     = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(12);
      wide  = ($urandom_range(15) == 0);
      fbase = 8'($urandom);
      for (int k = 0; k < n; k++) begin
         t[20:13] = wide ? 8'($urandom) : fbase + 8'($urandom_range(2));
         t[12:0]  = 13'($urandom);
         tdc      = ($urandom_range(9) == 0) ? 4'd15 : 4'($urandom_range(14));
         ch       = 3'($urandom);
         chain    = 1'($urandom);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               send_hit(chain, tdc, ch, EDGE_LEAD, t);
               if ($urandom_range(2) == 0)
                  send_hit(1'($urandom), 4'($urandom), 3'($urandom), 2'($urandom),
                           21'($urandom));
               send_hit(chain, tdc, ch, EDGE_TRAIL, t + 21'($urandom_range(3000)));
            end
            5, 6: send_hit(chain, tdc, ch, EDGE_LEAD, t);
            7:    send_hit(chain, tdc, ch, EDGE_TRAIL, t);
            default: send_hit(chain, tdc, ch, 2'($urandom_range(1) * 3), t);
         endcase
      end
      send_item(OP_BOARD, board_data(4'($urandom)));
   endtask

   initial begin
      int rand_start;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_START;
      req_tdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: header extremes, edge kinds, converter fifteen, wrapped width,
      // single use of a trailing hit, pulls past the end, unknown ops
      send_item(OP_START, start_data(7'h7F, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF));
      send_item(OP_START, start_data(7'h00, 12'h000, 12'h000, 32'h0000_0000));
      send_hit(1'b1, LAST_TDC, 3'd7, EDGE_LEAD, 21'h1F_FFFF);
      send_hit(1'b1, LAST_TDC, 3'd7, EDGE_TRAIL, 21'd5);
      send_hit(1'b1, 4'd15, 3'd3, EDGE_LEAD, 21'd40);
      send_hit(1'b1, 4'd15, 3'd3, EDGE_TRAIL, 21'd50);
      send_hit(1'b0, 4'd2, 3'd1, 2'd0, 21'd60);
      send_hit(1'b0, 4'd2, 3'd1, 2'd3, 21'd70);
      send_hit(1'b0, 4'd0, 3'd0, EDGE_LEAD, 21'd0);
      send_hit(1'b0, 4'd5, 3'd2, EDGE_LEAD, 21'd100);
      send_hit(1'b0, 4'd5, 3'd2, EDGE_LEAD, 21'd200);
      send_hit(1'b0, 4'd5, 3'd2, EDGE_TRAIL, 21'd300);
      send_item(OP_BOARD, board_data(4'd15));
      repeat (7) send_item(OP_PULL, rnd_data());
      send_item(3'd5, rnd_data());
      send_item(3'd7, rnd_data());
      send_item(OP_BOARD, board_data(4'd9));
      send_item(OP_PULL, rnd_data());
      send_item(OP_END, end_data(31'h7FFF_FFFF));
      send_item(OP_END, end_data(31'h0));

      rand_start = items_sent;
      snd_idle = 36;
      rcv_idle = 77;

      // store full and frame full: more hits than the store holds, all in one frame
      send_start();
      for (int k = 0; k < MAX_HITS + 2; k++)
         send_hit(1'b0, 4'd0, 3'($urandom), EDGE_LEAD, {8'd17, 13'($urandom)});
      send_item(OP_BOARD, board_data(4'd3));
      drain_board();

      while (items_sent - rand_start < 850) begin
         if (items_sent - rand_start >= 566 && snd_idle != 0) begin
            snd_idle = 0;
            rcv_idle = 0;
            hold_req = 1;   // long stall of the receiver while items keep coming
         end else if (items_sent - rand_start >= 283 && snd_idle == 36) begin
            snd_idle = 77;
            rcv_idle = 36;
         end
         if ($urandom_range(9) != 0)
            send_start();
         repeat ($urandom_range(1, 3)) begin
            rand_board();
            drain_board();
            if ($urandom_range(15) == 0)
               send_item(3'($urandom_range(5, 7)), rnd_data());
         end
         if ($urandom_range(9) != 0)
            send_item(OP_END, end_data(31'($urandom)));
      end
      send_item(OP_END, end_data(31'($urandom)));
      req_tvalid <= 1'b0;

      while (sb.pend_words.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);

      $display("run covered %0d input items and %0d result words, longest pull run %0d",
               items_sent, sb.n_checked, max_pull_run);
      $display("phases: sender/receiver idling 36/77, 77/36, none, with one long receiver hold-off");
      if (sb.errors == 0 && sb.pend_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d words left over", sb.errors, sb.pend_words.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
